// ----- sv/sph_pkg.sv -----
// ----------------------------------------------------------------------------
// sph_pkg
// Shared constants and the queue word type for the sliding puzzle
// heuristics unit.
// ----------------------------------------------------------------------------
package sph_pkg;

   // board geometry
   localparam int MAX_SIDE = 8;
   localparam int CELLS    = MAX_SIDE * MAX_SIDE;
   localparam int CELL_W   = $clog2(CELLS);

   // field widths
   localparam int COORD_W = 3;
   localparam int TILE_W  = 6;
   localparam int TILES   = 2 ** TILE_W;
   localparam int MIS_W   = 7;
   localparam int DIST_W  = 10;
   localparam int STEP_W  = COORD_W + 1;

   // saturation limits
   localparam logic [MIS_W-1:0]  MIS_MAX  = '1;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // front to back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // op codes
   localparam logic OP_GOAL  = 1'b0;
   localparam logic OP_STATE = 1'b1;

   // classified word handed from front to back
   typedef struct packed {
      logic                 is_goal;
      logic                 on_board;
      logic [CELL_W-1:0]    cell_idx;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      logic [TILE_W-1:0]    tile;
      logic                 last;
   } q_item_type;

endpackage

// ----- sv/sph_front.sv -----
// ----------------------------------------------------------------------------
// sph_front
// Accepts request words, classifies them (goal or state, on the board, cell
// index) and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module sph_front
   import sph_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [COORD_W-1:0]   req_row,
   input  logic [COORD_W-1:0]   req_col,
   input  logic [TILE_W-1:0]    req_tile,
   input  logic                 req_last_tile,
   output logic                 q_valid,
   output q_item_type           q_item,
   input  logic                 q_pop
);

   q_item_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   q_item_type          class_item;
   logic                push;
   int                  cell_wide;

   // classify the incoming word
   always_comb begin
      cell_wide           = int'(req_row) * MAX_SIDE + int'(req_col);
      class_item.is_goal  = (req_op == OP_GOAL);
      class_item.on_board = (int'(req_row) < MAX_SIDE) && (int'(req_col) < MAX_SIDE);
      class_item.cell_idx = cell_wide[CELL_W-1:0];
      class_item.row      = req_row;
      class_item.col      = req_col;
      class_item.tile     = req_tile;
      class_item.last     = req_last_tile;
   end

   // queue handshake
   assign req_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= class_item;
      end
   end

endmodule

// ----- sv/sph_back.sv -----
// ----------------------------------------------------------------------------
// sph_back
// Holds the goal board and goal position tables, looks up each state word,
// accumulates misplaced count and Manhattan sum, and drives the result word.
// ----------------------------------------------------------------------------
module sph_back
   import sph_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  q_item_type           q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [MIS_W-1:0]     rsp_misplaced_count,
   output logic [DIST_W-1:0]    rsp_manhattan_sum
);

   // goal tables
   logic [TILE_W-1:0]    board_mem   [CELLS];
   logic [COORD_W-1:0]   pos_row_mem [TILES];
   logic [COORD_W-1:0]   pos_col_mem [TILES];
   logic [TILES-1:0]     pos_valid_ff, pos_valid_in;
   logic                 goal_complete_ff, goal_complete_in;

   // lookup stage
   logic                 b_valid_ff;
   q_item_type           b_item_ff;
   logic [TILE_W-1:0]    board_rd_ff;
   logic [COORD_W-1:0]   pos_row_rd_ff;
   logic [COORD_W-1:0]   pos_col_rd_ff;
   logic                 pos_vld_rd_ff;

   // accumulators and result register
   logic [MIS_W-1:0]     mis_acc_ff, mis_acc_in;
   logic [DIST_W-1:0]    dist_acc_ff, dist_acc_in;
   logic                 rsp_valid_ff;
   logic [MIS_W-1:0]     rsp_mis_ff;
   logic [DIST_W-1:0]    rsp_dist_ff;

   logic                 b_emit, out_free, b_adv, b_retire;
   logic                 goal_write;
   logic                 mis_hit, dist_add;
   logic [COORD_W-1:0]   dr, dc;
   logic [STEP_W-1:0]    step;
   logic [DIST_W:0]      dist_sum;

   // flow control: the lookup stage stalls only on a final word with the result busy
   assign b_emit   = b_valid_ff && !b_item_ff.is_goal && b_item_ff.last;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_adv    = !b_emit || out_free;
   assign q_pop    = q_valid && b_adv;
   assign b_retire = b_valid_ff && b_adv && !b_item_ff.is_goal;

   assign goal_write = q_pop && q_item.is_goal && q_item.on_board;

   // valid marks and goal load tracking
   always_comb begin
      pos_valid_in     = pos_valid_ff;
      goal_complete_in = goal_complete_ff;
      if (q_pop && q_item.is_goal) begin
         if (goal_complete_ff) begin
            pos_valid_in = '0;
         end
         if (q_item.on_board) begin
            pos_valid_in[q_item.tile] = 1'b1;
         end
         goal_complete_in = q_item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff     <= '0;
         goal_complete_ff <= 1'b1;
      end else begin
         pos_valid_ff     <= pos_valid_in;
         goal_complete_ff <= goal_complete_in;
      end
   end

   // goal board memory
   always_ff @(posedge clock) begin
      if (goal_write) begin
         board_mem[q_item.cell_idx] <= q_item.tile;
      end
      if (q_pop) begin
         board_rd_ff <= board_mem[q_item.cell_idx];
      end
   end

   // goal position memory
   always_ff @(posedge clock) begin
      if (goal_write) begin
         pos_row_mem[q_item.tile] <= q_item.row;
         pos_col_mem[q_item.tile] <= q_item.col;
      end
      if (q_pop) begin
         pos_row_rd_ff <= pos_row_mem[q_item.tile];
         pos_col_rd_ff <= pos_col_mem[q_item.tile];
      end
   end

   // lookup stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_adv) begin
         b_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_item_ff     <= q_item;
         pos_vld_rd_ff <= pos_valid_ff[q_item.tile];
      end
   end

   // misplaced and distance terms
   always_comb begin
      mis_hit  = b_item_ff.on_board && (board_rd_ff != '0) && (board_rd_ff != b_item_ff.tile);
      dist_add = b_item_ff.on_board && (b_item_ff.tile != '0) && pos_vld_rd_ff;
      dr = (b_item_ff.row >= pos_row_rd_ff) ? b_item_ff.row - pos_row_rd_ff
                                            : pos_row_rd_ff - b_item_ff.row;
      dc = (b_item_ff.col >= pos_col_rd_ff) ? b_item_ff.col - pos_col_rd_ff
                                            : pos_col_rd_ff - b_item_ff.col;
      step     = STEP_W'(dr) + STEP_W'(dc);
      dist_sum = (DIST_W+1)'(dist_acc_ff) + (DIST_W+1)'(step);

      mis_acc_in = mis_acc_ff;
      if (mis_hit && (mis_acc_ff != MIS_MAX)) begin
         mis_acc_in = mis_acc_ff + 1'b1;
      end
      dist_acc_in = dist_acc_ff;
      if (dist_add) begin
         dist_acc_in = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
      end
   end

   // accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         mis_acc_ff  <= '0;
         dist_acc_ff <= '0;
      end else if (b_retire) begin
         if (b_item_ff.last) begin
            mis_acc_ff  <= '0;
            dist_acc_ff <= '0;
         end else begin
            mis_acc_ff  <= mis_acc_in;
            dist_acc_ff <= dist_acc_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_retire && b_item_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_retire && b_item_ff.last) begin
         rsp_mis_ff  <= mis_acc_in;
         rsp_dist_ff <= dist_acc_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_misplaced_count = rsp_mis_ff;
   assign rsp_manhattan_sum   = rsp_dist_ff;

endmodule

// ----- sv/sliding_puzzle_heuristics_unit.sv -----
// ----------------------------------------------------------------------------
// sliding_puzzle_heuristics_unit
// Misplaced-tile count and Manhattan distance for a sliding tile puzzle.
//
//   channel   direction  handshake            word
//   req_      in         req_valid/req_ready  op, row, col, tile, last_tile
//   rsp_      out        rsp_valid/rsp_ready  misplaced_count, manhattan_sum
//
// One tile word per cycle sustained while no result is stalled; the back end
// takes one word a cycle through one read of each goal table and one accumulate.
// A result is registered once its final state word leaves the lookup stage.
// Reset clears the queue, valid marks and accumulators; the goal board holds
// no defined contents until a goal load writes it.
// A stalled result holds the final state word in the lookup stage; the front
// queue then fills and req_ready drops after at most four more words.
// ----------------------------------------------------------------------------
module sliding_puzzle_heuristics_unit
   import sph_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [COORD_W-1:0]   req_row,
   input  logic [COORD_W-1:0]   req_col,
   input  logic [TILE_W-1:0]    req_tile,
   input  logic                 req_last_tile,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [MIS_W-1:0]     rsp_misplaced_count,
   output logic [DIST_W-1:0]    rsp_manhattan_sum
);

   logic        q_valid;
   logic        q_pop;
   q_item_type  q_item;

   // accept and classify
   sph_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_tile      (req_tile),
      .req_last_tile (req_last_tile),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   // lookup and accumulate
   sph_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_misplaced_count (rsp_misplaced_count),
      .rsp_manhattan_sum   (rsp_manhattan_sum)
   );

endmodule

// ----- sv/sph_checker.sv -----
// ----------------------------------------------------------------------------
// sph_checker
// Port-level checks for the sliding puzzle heuristics unit.
// ----------------------------------------------------------------------------
module sph_checker
   import sph_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [MIS_W-1:0]     rsp_misplaced_count,
   input  logic [DIST_W-1:0]    rsp_manhattan_sum
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_misplaced_count)
                                            && $stable(rsp_manhattan_sum))
      else $error("result word changed while stalled");

   // no result word right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the queue fills only by accepting a word
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && req_ready))
      else $error("req_ready dropped without an accepted word");

endmodule

bind sliding_puzzle_heuristics_unit sph_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_misplaced_count (rsp_misplaced_count),
   .rsp_manhattan_sum   (rsp_manhattan_sum)
);
